// ===== rtl/core/gspm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspm_pkg
// Types, constants and packet tables of the gamepad serial poll master.
// ----------------------------------------------------------------------------
package gspm_pkg;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_PRE   = 3'd1,
      PH_LOW   = 3'd2,
      PH_HIGH  = 3'd3,
      PH_GAP   = 3'd4,
      PH_INTER = 3'd5,
      PH_DONE  = 3'd6
   } phase_type;

   localparam logic [1:0] REQ_NONE = 2'd0;
   localparam logic [1:0] REQ_POLL = 2'd1;
   localparam logic [1:0] REQ_INIT = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_GAP   = 2'd2;

   localparam logic [7:0] CLOCK_LOW_RESET  = 8'd4;
   localparam logic [7:0] CLOCK_HIGH_RESET = 8'd1;
   localparam logic [7:0] BYTE_GAP_RESET   = 8'd4;

   localparam int unsigned RX_DEPTH = 9;

   localparam logic [1:0] PKT_POLL = 2'd0;
   localparam logic [1:0] PKT_LAST = 2'd3;

   function automatic logic [3:0] pkt_len(input logic [1:0] pkt);
      logic [3:0] len;
      unique case (pkt)
         2'd1:    len = 4'd5;
         default: len = 4'd9;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] pkt_byte(input logic [1:0] pkt, input logic [3:0] idx);
      logic [7:0] val;
      val = 8'h00;
      if (idx == 4'd0) begin
         val = 8'h01;
      end else if (idx == 4'd1) begin
         unique case (pkt)
            2'd0:    val = 8'h42;
            2'd2:    val = 8'h44;
            default: val = 8'h43;
         endcase
      end else if (idx == 4'd3) begin
         val = (pkt == 2'd1 || pkt == 2'd2) ? 8'h01 : 8'h00;
      end else if (idx == 4'd4) begin
         unique case (pkt)
            2'd2:    val = 8'h03;
            2'd3:    val = 8'h5A;
            default: val = 8'h00;
         endcase
      end else if (idx >= 4'd5 && idx <= 4'd8) begin
         val = (pkt == 2'd3) ? 8'h5A : 8'h00;
      end
      return val;
   endfunction

endpackage

// ===== rtl/core/gamepad_serial_poll_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_serial_poll_master
// Full-duplex serial gamepad bus master, one time-base tick per transfer.
// ----------------------------------------------------------------------------
// Each request transfer is one tick of the bus time base: the block takes
// one every clock cycle unless stalled and returns one response transfer
// per tick in the next cycle, from a single output register; a new tick
// is taken while the previous response waits as long as that register is
// being emptied in the same cycle. The line levels in a response reflect
// the sequencer state at the start of that tick, and the queries read the
// received bytes as they stood before it. A poll (req_type 1) waits one
// byte gap with attention low, sends 01 42 and seven zeros LSB first and
// stores the nine replies; init (req_type 2) follows the poll with
// enter-config, lock-analog and exit-config packets. Requests while busy
// are dropped. Timing registers count ticks; zero acts as one.
module gamepad_serial_poll_master
   import gspm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_type,
   input  logic                   req_data_bit,
   input  logic [15:0]            req_button_mask,
   input  logic [3:0]             req_stick_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_clock_out,
   output logic                   rsp_command_out,
   output logic                   rsp_attention_out,
   output logic                   rsp_busy_res,
   output logic                   rsp_done_res,
   output logic                   rsp_button_pressed,
   output logic [7:0]             rsp_stick_value,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   logic [7:0] clock_low_ff, clock_high_ff, byte_gap_ff;

   phase_type  phase_ff, phase_in;
   logic [7:0] tick_ff, tick_in;
   logic [2:0] bit_ff, bit_in;
   logic [3:0] byte_ff, byte_in;
   logic [1:0] pkt_ff, pkt_in;
   logic       init_ff, init_in;
   logic [7:0] tx_ff, tx_in;
   logic [7:0] rx_ff, rx_in;
   logic [7:0] rx_bytes_ff [RX_DEPTH];
   logic       store_en;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       clk_ff, cmd_ff, att_ff, busy_ff, done_ff, pressed_ff;
   logic [7:0] stick_ff;
   logic       clk_in, cmd_in, att_in, busy_in, done_in, pressed_in;
   logic [7:0] stick_in;

   logic       accept;
   logic [7:0] lim_low, lim_high, lim_gap;
   logic [8:0] tick_next;
   logic       exp_low, exp_high, exp_gap;
   logic [3:0] byte_next;
   logic [1:0] pkt_next;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_low_ff  <= CLOCK_LOW_RESET;
         clock_high_ff <= CLOCK_HIGH_RESET;
         byte_gap_ff   <= BYTE_GAP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CLOCK_LOW:  clock_low_ff  <= csr_wdata;
            CSR_CLOCK_HIGH: clock_high_ff <= csr_wdata;
            CSR_BYTE_GAP:   byte_gap_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign lim_low   = (clock_low_ff  == 8'd0) ? 8'd1 : clock_low_ff;
   assign lim_high  = (clock_high_ff == 8'd0) ? 8'd1 : clock_high_ff;
   assign lim_gap   = (byte_gap_ff   == 8'd0) ? 8'd1 : byte_gap_ff;
   assign tick_next = {1'b0, tick_ff} + 9'd1;
   assign exp_low   = tick_next >= {1'b0, lim_low};
   assign exp_high  = tick_next >= {1'b0, lim_high};
   assign exp_gap   = tick_next >= {1'b0, lim_gap};
   assign byte_next = byte_ff + 4'd1;
   assign pkt_next  = pkt_ff + 2'd1;

   // sequencer next state
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      pkt_in   = pkt_ff;
      init_in  = init_ff;
      tx_in    = tx_ff;
      rx_in    = rx_ff;
      store_en = 1'b0;
      unique case (phase_ff)
         PH_PRE, PH_INTER: begin
            if (exp_gap) begin
               phase_in = PH_LOW;
               tick_in  = 8'd0;
            end else begin
               tick_in = tick_next[7:0];
            end
         end
         PH_LOW: begin
            if (exp_low) begin
               rx_in    = rx_ff | (8'({req_data_bit}) << bit_ff);
               phase_in = PH_HIGH;
               tick_in  = 8'd0;
            end else begin
               tick_in = tick_next[7:0];
            end
         end
         PH_HIGH: begin
            if (exp_high) begin
               tick_in = 8'd0;
               tx_in   = {1'b1, tx_ff[7:1]};
               if (bit_ff == 3'd7) begin
                  store_en = (pkt_ff == PKT_POLL) && (byte_ff < 4'(RX_DEPTH));
                  bit_in   = 3'd0;
                  phase_in = PH_GAP;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = PH_LOW;
               end
            end else begin
               tick_in = tick_next[7:0];
            end
         end
         PH_GAP: begin
            if (exp_gap) begin
               tick_in = 8'd0;
               byte_in = byte_next;
               if (byte_next < pkt_len(pkt_ff)) begin
                  tx_in    = pkt_byte(pkt_ff, byte_next);
                  rx_in    = 8'd0;
                  phase_in = PH_LOW;
               end else if (init_ff && pkt_ff != PKT_LAST) begin
                  pkt_in   = pkt_next;
                  byte_in  = 4'd0;
                  tx_in    = pkt_byte(pkt_next, 4'd0);
                  rx_in    = 8'd0;
                  phase_in = PH_INTER;
               end else begin
                  phase_in = PH_DONE;
               end
            end else begin
               tick_in = tick_next[7:0];
            end
         end
         default: begin
            if (req_type == REQ_POLL || req_type == REQ_INIT) begin
               init_in  = (req_type == REQ_INIT);
               phase_in = PH_PRE;
               tick_in  = 8'd0;
               bit_in   = 3'd0;
               byte_in  = 4'd0;
               pkt_in   = PKT_POLL;
               tx_in    = pkt_byte(PKT_POLL, 4'd0);
               rx_in    = 8'd0;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      endcase
   end

   // response fields from the state at the start of the tick
   always_comb begin
      clk_in  = 1'b1;
      cmd_in  = 1'b1;
      att_in  = 1'b1;
      busy_in = 1'b0;
      done_in = 1'b0;
      unique case (phase_ff)
         PH_PRE, PH_GAP: begin
            att_in  = 1'b0;
            busy_in = 1'b1;
         end
         PH_LOW: begin
            clk_in  = 1'b0;
            cmd_in  = tx_ff[0];
            att_in  = 1'b0;
            busy_in = 1'b1;
         end
         PH_HIGH: begin
            cmd_in  = tx_ff[0];
            att_in  = 1'b0;
            busy_in = 1'b1;
         end
         PH_INTER: busy_in = 1'b1;
         PH_DONE:  done_in = 1'b1;
         default: ;
      endcase
      pressed_in = |(~{rx_bytes_ff[4], rx_bytes_ff[3]} & req_button_mask);
      stick_in   = (req_stick_index < 4'(RX_DEPTH)) ? rx_bytes_ff[req_stick_index] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= 8'd0;
         bit_ff   <= 3'd0;
         byte_ff  <= 4'd0;
         pkt_ff   <= 2'd0;
         init_ff  <= 1'b0;
         tx_ff    <= 8'hFF;
         rx_ff    <= 8'd0;
         for (int i = 0; i < RX_DEPTH; i++) begin
            rx_bytes_ff[i] <= 8'hFF;
         end
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         pkt_ff   <= pkt_in;
         init_ff  <= init_in;
         tx_ff    <= tx_in;
         rx_ff    <= rx_in;
         if (store_en) begin
            rx_bytes_ff[byte_ff] <= rx_ff;
         end
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         clk_ff     <= clk_in;
         cmd_ff     <= cmd_in;
         att_ff     <= att_in;
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         pressed_ff <= pressed_in;
         stick_ff   <= stick_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_clock_out      = clk_ff;
   assign rsp_command_out    = cmd_ff;
   assign rsp_attention_out  = att_ff;
   assign rsp_busy_res       = busy_ff;
   assign rsp_done_res       = done_ff;
   assign rsp_button_pressed = pressed_ff;
   assign rsp_stick_value    = stick_ff;

endmodule

// ===== rtl/core/gspm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspm_checker
// Port-level checks of the gamepad serial poll master, bound to the top.
// ----------------------------------------------------------------------------
module gspm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_clock_out,
   input logic       rsp_command_out,
   input logic       rsp_attention_out,
   input logic       rsp_busy_res,
   input logic       rsp_done_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response transfer dropped while stalled");

   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_busy_res && rsp_done_res))
      else $error("busy and done shown together");

   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |->
         rsp_clock_out && rsp_command_out && rsp_attention_out)
      else $error("bus lines not idle outside a sequence");

   a_clock_in_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_clock_out |-> !rsp_attention_out && rsp_busy_res)
      else $error("clock low outside a packet");

endmodule

bind gamepad_serial_poll_master gspm_checker u_gspm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_clock_out     (rsp_clock_out),
   .rsp_command_out   (rsp_command_out),
   .rsp_attention_out (rsp_attention_out),
   .rsp_busy_res      (rsp_busy_res),
   .rsp_done_res      (rsp_done_res)
);
